// File: src/ptcs_pkg.sv
`timescale 1ns / 1ps

package ptcs_pkg;

    // default geometry
    localparam int ENTRIES_DEF = 8;
    localparam int TABLES_DEF  = 64;
    localparam int FRAMES_DEF  = 1024;

    // control register
    localparam int         CFG_W     = 4;
    localparam logic [3:0] EIU_RESET = 4'd8;
    localparam logic [1:0] ADDR_EIU  = 2'd0;

    // walk counter: holds up to the largest entries_in_use value
    localparam int CNT_W = 4;

    typedef enum logic [3:0] {
        ACT_READ     = 4'd0,
        ACT_WRITE    = 4'd1,
        ACT_SWAP_OUT = 4'd2,
        ACT_SWAP_IN  = 4'd3,
        ACT_ASSIGN   = 4'd4,
        ACT_CLEAR    = 4'd5,
        ACT_QUERY    = 4'd6,
        ACT_SET_SWAP = 4'd7,
        ACT_SET_USE  = 4'd8,
        ACT_SCAN     = 4'd9
    } action_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SWEEP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RD,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [3:0] action;
        logic [5:0] table_index;
        logic [2:0] entry_index;
        logic [9:0] frame_number;
        logic       bit_value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [10:0] frame_out;
        logic               present;
        logic               used;
        logic               modified;
        logic               in_swap;
        logic               need_copy;
        logic               victim_found;
        logic [2:0]         victim_index;
    } res_word_t;

    typedef struct packed {
        logic signed [10:0] frame;
        logic               present;
        logic               used;
        logic               modified;
        logic               in_swap;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   need;
        logic   write;
    } alu_res_t;

    localparam entry_t ENTRY_RESET = '{
        frame:    11'h7FF,
        present:  1'b0,
        used:     1'b0,
        modified: 1'b0,
        in_swap:  1'b0
    };

endpackage

// File: src/ptcs_mem.sv
`timescale 1ns / 1ps

// single write port, single registered read port
module ptcs_mem #(
    parameter int DEPTH = ptcs_pkg::TABLES_DEF * ptcs_pkg::ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  ptcs_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output ptcs_pkg::entry_t  rdata
);

    ptcs_pkg::entry_t mem [DEPTH];
    ptcs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ptcs_alu.sv
`timescale 1ns / 1ps

// entry update: one read-modify-write step for any action
module ptcs_alu (
    input  logic [3:0]           action,
    input  ptcs_pkg::entry_t     cur,
    input  logic [9:0]           frame_number,
    input  logic                 bit_value,
    input  logic                 frame_ok,
    output ptcs_pkg::alu_res_t   res
);

    always_comb
    begin
        res.entry = cur;
        res.need  = 1'b0;
        res.write = 1'b0;
        unique case (ptcs_pkg::action_t'(action))
            ptcs_pkg::ACT_READ:
            begin
                res.entry.used = 1'b1;
                res.write      = 1'b1;
            end
            ptcs_pkg::ACT_WRITE:
            begin
                res.entry.used     = 1'b1;
                res.entry.modified = 1'b1;
                res.write          = 1'b1;
            end
            ptcs_pkg::ACT_SWAP_OUT:
            begin
                res.entry.present = 1'b0;
                if (cur.modified)
                begin
                    res.entry.in_swap = 1'b1;
                    res.need          = 1'b1;
                end
                res.write = 1'b1;
            end
            ptcs_pkg::ACT_SWAP_IN:
            begin
                if (frame_ok)
                begin
                    res.entry.frame    = 11'({1'b0, frame_number});
                    res.entry.present  = 1'b1;
                    res.entry.used     = 1'b0;
                    res.entry.modified = 1'b0;
                    res.need           = cur.in_swap;
                    res.write          = 1'b1;
                end
            end
            ptcs_pkg::ACT_ASSIGN:
            begin
                if (frame_ok)
                begin
                    res.entry.frame   = 11'({1'b0, frame_number});
                    res.entry.present = 1'b1;
                    res.write         = 1'b1;
                end
            end
            ptcs_pkg::ACT_SET_SWAP:
            begin
                res.entry.in_swap = bit_value;
                res.write         = 1'b1;
            end
            ptcs_pkg::ACT_SET_USE:
            begin
                res.entry.used = bit_value;
                res.write      = 1'b1;
            end
            ptcs_pkg::ACT_SCAN:
            begin
                // one clock-hand step: a present, recently used entry gets a second chance
                if (cur.present && cur.used)
                begin
                    res.entry.used = 1'b0;
                    res.write      = 1'b1;
                end
            end
            default:
            begin
                res.write = 1'b0;
            end
        endcase
    end

endmodule

// File: src/ptcs_ctrl.sv
`timescale 1ns / 1ps

// sequencer: init pass, table sweep, clock walk and single-entry update
module ptcs_ctrl #(
    parameter int ENTRIES = ptcs_pkg::ENTRIES_DEF,
    parameter int TABLES  = ptcs_pkg::TABLES_DEF,
    parameter int FRAMES  = ptcs_pkg::FRAMES_DEF,
    parameter int DEPTH   = TABLES * ENTRIES,
    parameter int AW      = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  ptcs_pkg::cmd_word_t     cmd,
    output logic                    res_valid,
    input  logic                    res_ready,
    output ptcs_pkg::res_word_t     res,
    input  logic [ptcs_pkg::CNT_W-1:0] limit,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output ptcs_pkg::entry_t        mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  ptcs_pkg::entry_t        mem_rdata
);

    ptcs_pkg::state_t    state_reg, state_next;
    ptcs_pkg::cmd_word_t cmd_reg, cmd_next;
    logic                oor_reg, oor_next;
    logic                found_reg, found_next;
    logic [ptcs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]       init_ptr_reg, init_ptr_next;
    ptcs_pkg::res_word_t res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    ptcs_pkg::alu_res_t  alu;
    logic                frame_ok;
    logic                is_scan;
    logic                slot_free;

    function automatic logic [AW-1:0] ent_addr(input logic [5:0] t,
                                               input logic [ptcs_pkg::CNT_W-1:0] e);
        return AW'(int'(t) * ENTRIES + int'(e));
    endfunction

    assign frame_ok  = int'(cmd_reg.frame_number) < FRAMES;
    assign is_scan   = ptcs_pkg::action_t'(cmd_reg.action) == ptcs_pkg::ACT_SCAN;
    assign slot_free = !res_valid_reg || res_ready;

    ptcs_alu u_alu (
        .action       (cmd_reg.action),
        .cur          (mem_rdata),
        .frame_number (cmd_reg.frame_number),
        .bit_value    (cmd_reg.bit_value),
        .frame_ok     (frame_ok),
        .res          (alu)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptcs_pkg::S_INIT;
            init_ptr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_ptr_reg  <= init_ptr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        oor_reg   <= oor_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        oor_next       = oor_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        init_ptr_next  = init_ptr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ent_addr(cmd_reg.table_index, cnt_reg);
        mem_wdata      = ptcs_pkg::ENTRY_RESET;
        mem_re         = 1'b0;
        mem_raddr      = ent_addr(cmd_reg.table_index, cnt_reg);

        unique case (state_reg)
            ptcs_pkg::S_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_ptr_reg;
                init_ptr_next = init_ptr_reg + 1'b1;
                if (init_ptr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ptcs_pkg::S_IDLE;
                end
            end
            ptcs_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    found_next = 1'b0;
                    oor_next   = (int'(cmd.table_index) >= TABLES)
                              || (int'(cmd.entry_index) >= ENTRIES);
                    if ((int'(cmd.table_index) >= TABLES)
                        || (int'(cmd.entry_index) >= ENTRIES))
                    begin
                        state_next = ptcs_pkg::S_FIN;
                    end
                    else if (ptcs_pkg::action_t'(cmd.action) == ptcs_pkg::ACT_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = ptcs_pkg::S_SWEEP;
                    end
                    else if (ptcs_pkg::action_t'(cmd.action) == ptcs_pkg::ACT_SCAN)
                    begin
                        cnt_next   = ptcs_pkg::CNT_W'({1'b0, cmd.entry_index});
                        state_next = ptcs_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ptcs_pkg::S_RD;
                    end
                end
            end
            ptcs_pkg::S_SWEEP:
            begin
                if (cnt_reg < limit)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ptcs_pkg::S_RD;
                end
            end
            ptcs_pkg::S_SCAN_RD:
            begin
                if (cnt_reg < limit)
                begin
                    mem_re     = 1'b1;
                    state_next = ptcs_pkg::S_SCAN_CHK;
                end
                else
                begin
                    // hand ran off the end: report the addressed entry as it now is
                    state_next = ptcs_pkg::S_RD;
                end
            end
            ptcs_pkg::S_SCAN_CHK:
            begin
                if (mem_rdata.present && !mem_rdata.used)
                begin
                    found_next = 1'b1;
                    state_next = ptcs_pkg::S_FIN;
                end
                else
                begin
                    mem_we     = alu.write;
                    mem_wdata  = alu.entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ptcs_pkg::S_SCAN_RD;
                end
            end
            ptcs_pkg::S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ent_addr(cmd_reg.table_index,
                                      ptcs_pkg::CNT_W'({1'b0, cmd_reg.entry_index}));
                state_next = ptcs_pkg::S_FIN;
            end
            ptcs_pkg::S_FIN:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ptcs_pkg::S_IDLE;
                    if (oor_reg)
                    begin
                        res_next           = '0;
                        res_next.frame_out = ptcs_pkg::ENTRY_RESET.frame;
                    end
                    else
                    begin
                        // scan leaves the reported entry as read; others take the update
                        mem_we    = alu.write && !is_scan;
                        mem_waddr = ent_addr(cmd_reg.table_index,
                                             ptcs_pkg::CNT_W'({1'b0, cmd_reg.entry_index}));
                        mem_wdata = alu.entry;
                        res_next.frame_out    = is_scan ? mem_rdata.frame : alu.entry.frame;
                        res_next.present      = is_scan ? mem_rdata.present
                                                        : alu.entry.present;
                        res_next.used         = is_scan ? mem_rdata.used : alu.entry.used;
                        res_next.modified     = is_scan ? mem_rdata.modified
                                                        : alu.entry.modified;
                        res_next.in_swap      = is_scan ? mem_rdata.in_swap
                                                        : alu.entry.in_swap;
                        res_next.need_copy    = !is_scan && alu.need;
                        res_next.victim_found = found_reg;
                        res_next.victim_index = found_reg ? cnt_reg[2:0] : 3'd0;
                    end
                end
            end
            default:
            begin
                state_next = ptcs_pkg::S_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: src/page_table_with_clock_scan.sv
`timescale 1ns / 1ps
// Work per word: a plain action reads its entry, then updates it and registers the result
// word once the output slot is free; a clear first writes the reset entry over the entries
// in use; a walk reads and checks entries from the addressed one until it stops on a victim
// or passes the limit. A new word is taken only after the last result is registered; the
// shared entry port, one access per cycle, sets the walk and sweep lengths.
// Reset: asynchronous, active low; a pass over all TABLES*ENTRIES entries (512 by default)
// then clears the store, with cmd_ready low until it ends.

module page_table_with_clock_scan #(
    parameter int ENTRIES = ptcs_pkg::ENTRIES_DEF,
    parameter int TABLES  = ptcs_pkg::TABLES_DEF,
    parameter int FRAMES  = ptcs_pkg::FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // command words
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  ptcs_pkg::cmd_word_t  cmd,

    // result words
    output logic                 res_valid,
    input  logic                 res_ready,
    output ptcs_pkg::res_word_t  res,

    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DEPTH = TABLES * ENTRIES;
    localparam int AW    = $clog2(DEPTH);

    // entries_in_use: how many entries of a table the clear and the walk cover
    logic [ptcs_pkg::CFG_W-1:0]  eiu_reg;
    logic [ptcs_pkg::CNT_W-1:0]  limit;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    ptcs_pkg::entry_t            mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    ptcs_pkg::entry_t            mem_rdata;

    assign pready = 1'b1;

    // a single register: every completed write lands in it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= ptcs_pkg::EIU_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            eiu_reg <= pwdata[ptcs_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr == ptcs_pkg::ADDR_EIU) ? {28'd0, eiu_reg} : 32'd0;

    // values above the table size act as the table size
    assign limit = (int'(eiu_reg) > ENTRIES) ? ptcs_pkg::CNT_W'(ENTRIES) : eiu_reg;

    // sequencer with the shared update unit
    ptcs_ctrl #(
        .ENTRIES (ENTRIES),
        .TABLES  (TABLES),
        .FRAMES  (FRAMES),
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .limit     (limit),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // page-table entry store, TABLES rows of ENTRIES entries
    ptcs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
